FILE: rtl/pmau_pkg.sv
// Shared types and constants for the prime-modulus arithmetic unit.
// Holds the modulus, the Barrett constant, the opcodes and the request/response
// structs between the sequencer and the modular multiplier. No dependencies.
package pmau_pkg;

	// Prime modulus 1e9+7 and the Fermat inverse exponent MOD-2
	localparam logic [29:0] MOD        = 30'd1000000007;
	localparam logic [31:0] FERMAT_EXP = 32'd1000000005;

	// Barrett reciprocal floor(2^60 / MOD)
	localparam logic [30:0] BARRETT_MU = 31'd1152921496;

	// Opcodes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_POW = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;

	// Sequencer -> modular multiplier
	typedef struct packed {
		logic        start;
		logic [31:0] x;
		logic [31:0] y;
	} mm_req_t;

	// Modular multiplier -> sequencer
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [29:0] result;
	} mm_rsp_t;

endpackage

FILE: rtl/pmau_modmul.sv
// Iterative modular multiplier: (x * y) mod MOD by Barrett reduction.
// One 32x32 multiplier is reused for the product, the quotient estimate and
// the quotient times modulus. Depends on pmau_pkg.
module pmau_modmul import pmau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_PROD = 5'b00010,
		PH_QEST = 5'b00100,
		PH_QMUL = 5'b01000,
		PH_CORR = 5'b10000
	} phase_t;

	phase_t      phase_q;
	logic        done_q;
	logic [31:0] x_q, y_q;
	logic [31:0] plo_q;
	logic [30:0] q1_q;
	logic [30:0] q_q;
	logic [31:0] r_q;
	logic [29:0] res_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [32:0] r_m1, r_m2;
	logic [29:0] r_fix;

	// Shared multiplier operand select
	always_comb begin
		unique case (phase_q)
			PH_PROD: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			PH_QEST: begin
				mul_a = {1'b0, q1_q};
				mul_b = {1'b0, BARRETT_MU};
			end
			PH_QMUL: begin
				mul_a = {1'b0, q_q};
				mul_b = {2'b0, MOD};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Remainder is below 3*MOD: at most two subtractions
	assign r_m1 = {1'b0, r_q} - {3'b0, MOD};
	assign r_m2 = {1'b0, r_q} - {2'b0, MOD, 1'b0};

	always_comb begin
		priority if (!r_m2[32]) begin
			r_fix = r_m2[29:0];
		end else if (!r_m1[32]) begin
			r_fix = r_m1[29:0];
		end else begin
			r_fix = r_q[29:0];
		end
	end

	// Phase sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: if (req.start) phase_q <= PH_PROD;
				PH_PROD: phase_q <= PH_QEST;
				PH_QEST: phase_q <= PH_QMUL;
				PH_QMUL: phase_q <= PH_CORR;
				PH_CORR: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			x_q <= req.x;
			y_q <= req.y;
		end
		if (phase_q == PH_PROD) begin
			plo_q <= mul_p[31:0];
			q1_q  <= mul_p[59:29];
		end
		if (phase_q == PH_QEST) begin
			q_q <= mul_p[61:31];
		end
		if (phase_q == PH_QMUL) begin
			r_q <= plo_q - mul_p[31:0];
		end
		if (phase_q == PH_CORR) begin
			res_q <= r_fix;
		end
	end

	assign rsp.busy   = (phase_q != PH_IDLE);
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

FILE: rtl/prime_modulus_arith_unit.sv
// Prime-modulus arithmetic unit, top level: sequencer, operand and power
// registers, output register. Depends on pmau_pkg and pmau_modmul.
//
//   channel | dir | handshake        | payload
//   s_*     | in  | s_tvalid/s_tready| s_tdata: opcode, value_a, value_b, exponent
//   m_*     | out | m_tvalid/m_tready| m_tdata: residue
//
// One item at a time. A modular multiply runs on the shared multiplier in the
// phases product, quotient estimate, quotient*MOD, correction and handoff.
// Every item first reduces both operands; add/sub then fold once, multiply adds
// one multiply, power squares per bit and multiplies per set bit, divide does a*b^(MOD-2).
// Reset is asynchronous, active low, and clears the sequencer and output valid.
// A stalled output holds its item; the next input is taken meanwhile.
module prime_modulus_arith_unit import pmau_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // [2:0] opcode, [34:3] value_a, [66:35] value_b,
	                               // [98:67] exponent, [103:99] zero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata   // [29:0] residue, [31:30] zero
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_RED_A    = 10'b0000000010,
		S_RED_B    = 10'b0000000100,
		S_DISPATCH = 10'b0000001000,
		S_MUL      = 10'b0000010000,
		S_POW_STEP = 10'b0000100000,
		S_POW_MUL  = 10'b0001000000,
		S_POW_SQR  = 10'b0010000000,
		S_FIN_MUL  = 10'b0100000000,
		S_DONE     = 10'b1000000000
	} state_t;

	state_t      state_q, state_d;
	logic        wait_q, wait_d;
	logic        out_valid_q, out_valid_d;
	logic [2:0]  opcode_q;
	logic [31:0] a_raw_q, b_raw_q;
	logic [31:0] exp_q, exp_d;
	logic [29:0] a_q, a_d, b_q, b_d;
	logic [29:0] acc_q, acc_d, sq_q, sq_d;
	logic [29:0] res_q, res_d;
	logic [29:0] out_data_q;
	logic        take_in, load_out;

	mm_req_t     mm_req;
	mm_rsp_t     mm_rsp;
	logic        mm_state;

	logic [30:0] sum_raw;
	logic [31:0] sum_fold;
	logic [29:0] addsub_res;

	pmau_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign s_tready = (state_q == S_IDLE);
	assign take_in  = s_tvalid && s_tready;

	// Add / subtract with one fold back into range
	assign sum_raw    = (opcode_q == OP_SUB) ? ({1'b0, a_q} + {1'b0, MOD} - {1'b0, b_q})
	                                         : ({1'b0, a_q} + {1'b0, b_q});
	assign sum_fold   = {1'b0, sum_raw} - {2'b0, MOD};
	assign addsub_res = sum_fold[31] ? sum_raw[29:0] : sum_fold[29:0];

	// Multiplier requests
	assign mm_state = (state_q == S_RED_A) || (state_q == S_RED_B) || (state_q == S_MUL) ||
	                  (state_q == S_POW_MUL) || (state_q == S_POW_SQR) ||
	                  (state_q == S_FIN_MUL);

	always_comb begin
		mm_req.start = mm_state && !wait_q;
		unique case (state_q)
			S_RED_A: begin
				mm_req.x = a_raw_q;
				mm_req.y = 32'd1;
			end
			S_RED_B: begin
				mm_req.x = b_raw_q;
				mm_req.y = 32'd1;
			end
			S_MUL: begin
				mm_req.x = {2'b0, a_q};
				mm_req.y = {2'b0, b_q};
			end
			S_POW_MUL: begin
				mm_req.x = {2'b0, acc_q};
				mm_req.y = {2'b0, sq_q};
			end
			S_POW_SQR: begin
				mm_req.x = {2'b0, sq_q};
				mm_req.y = {2'b0, sq_q};
			end
			S_FIN_MUL: begin
				mm_req.x = {2'b0, a_q};
				mm_req.y = {2'b0, acc_q};
			end
			default: begin
				mm_req.x = '0;
				mm_req.y = '0;
			end
		endcase
	end

	// Sequencer
	always_comb begin
		state_d  = state_q;
		exp_d    = exp_q;
		a_d      = a_q;
		b_d      = b_q;
		acc_d    = acc_q;
		sq_d     = sq_q;
		res_d    = res_q;
		load_out = 1'b0;

		wait_d = wait_q;
		if (mm_req.start) wait_d = 1'b1;
		if (mm_rsp.done)  wait_d = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (take_in) begin
					exp_d   = s_tdata[98:67];
					state_d = S_RED_A;
				end
			end
			S_RED_A: begin
				if (mm_rsp.done) begin
					a_d     = mm_rsp.result;
					state_d = S_RED_B;
				end
			end
			S_RED_B: begin
				if (mm_rsp.done) begin
					b_d     = mm_rsp.result;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (opcode_q)
					OP_ADD, OP_SUB: begin
						res_d   = addsub_res;
						state_d = S_DONE;
					end
					OP_MUL: state_d = S_MUL;
					OP_POW: begin
						acc_d   = 30'd1;
						sq_d    = b_q;
						state_d = S_POW_STEP;
					end
					OP_DIV: begin
						acc_d   = 30'd1;
						sq_d    = b_q;
						exp_d   = FERMAT_EXP;
						state_d = S_POW_STEP;
					end
					default: begin
						res_d   = '0;
						state_d = S_DONE;
					end
				endcase
			end
			S_MUL: begin
				if (mm_rsp.done) begin
					res_d   = mm_rsp.result;
					state_d = S_DONE;
				end
			end
			// one exponent bit per pass, low bit first
			S_POW_STEP: begin
				priority if (exp_q == '0) begin
					if (opcode_q == OP_DIV) begin
						state_d = S_FIN_MUL;
					end else begin
						res_d   = acc_q;
						state_d = S_DONE;
					end
				end else if (exp_q[0]) begin
					state_d = S_POW_MUL;
				end else begin
					state_d = S_POW_SQR;
				end
			end
			S_POW_MUL: begin
				if (mm_rsp.done) begin
					acc_d = mm_rsp.result;
					// no squaring needed after the top set bit
					if (exp_q[31:1] == '0) begin
						exp_d   = '0;
						state_d = S_POW_STEP;
					end else begin
						state_d = S_POW_SQR;
					end
				end
			end
			S_POW_SQR: begin
				if (mm_rsp.done) begin
					sq_d    = mm_rsp.result;
					exp_d   = {1'b0, exp_q[31:1]};
					state_d = S_POW_STEP;
				end
			end
			S_FIN_MUL: begin
				if (mm_rsp.done) begin
					res_d   = mm_rsp.result;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		out_valid_d = out_valid_q;
		if (out_valid_q && m_tready) out_valid_d = 1'b0;
		if (load_out)                out_valid_d = 1'b1;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wait_q      <= wait_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_q <= s_tdata[2:0];
			a_raw_q  <= s_tdata[34:3];
			b_raw_q  <= s_tdata[66:35];
		end
		if (load_out) out_data_q <= res_q;
		exp_q <= exp_d;
		a_q   <= a_d;
		b_q   <= b_d;
		acc_q <= acc_d;
		sq_q  <= sq_d;
		res_q <= res_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, out_data_q};

	// Multiplier results are always fully reduced
	a_mm_range: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (mm_rsp.result < MOD))
		else $error("modmul result not below modulus");

	// Multiplier is idle whenever a new item can be taken
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mm_rsp.busy)
		else $error("multiplier busy while sequencer idle");

	// A completion only arrives for an outstanding request
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> wait_q)
		else $error("unexpected multiplier completion");

	// Accepted item starts with operand reduction
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_RED_A))
		else $error("accepted item did not start reduction");

endmodule

FILE: sim/prime_modulus_arith_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for prime_modulus_arith_unit: drives opcode/operand items on
// the s_* stream, predicts each residue mod 1e9+7 and checks it on m_*.
// Depends on pmau_pkg (modulus, Fermat exponent, opcodes) and the RTL under test.
module prime_modulus_arith_unit_test;
	import pmau_pkg::*;

	// Opcodes with no defined function; the unit must answer them with 0
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam int RANDOM_OPS = 850;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic [2:0]  opcode;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [31:0] exponent;
		bit          hold;     // wait for all residues before sending
	} arith_op_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;  // [2:0] opcode, [34:3] value_a, [66:35] value_b,
	                             // [98:67] exponent, [103:99] zero
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;       // [29:0] residue, [31:30] zero

	arith_op_t   pending_ops[$];
	logic [29:0] residues_due[$];
	arith_op_t   next_op;
	logic [29:0] offered_residue = '0;
	logic [29:0] want;
	int          ops_sent = 0;
	int          residues_checked = 0;
	int          mismatches = 0;
	int          ops_by_code[8];

	prime_modulus_arith_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Residue arithmetic, done in 64 bits
	function automatic logic [29:0] mod_product(logic [29:0] x, logic [29:0] y);
		logic [63:0] p;
		p = 64'(x) * 64'(y);
		return 30'(p % 64'(MOD));
	endfunction

	function automatic logic [29:0] mod_power(logic [29:0] base, logic [31:0] e);
		logic [29:0] acc;
		logic [29:0] sq;
		acc = 30'd1;
		sq = base;
		for (int i = 0; i < 32; i++) begin
			if (e[i])
				acc = mod_product(acc, sq);
			sq = mod_product(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [29:0] residue_of(arith_op_t op);
		logic [63:0] a;
		logic [63:0] b;
		a = 64'(op.value_a) % 64'(MOD);
		b = 64'(op.value_b) % 64'(MOD);
		case (op.opcode)
			OP_ADD: return 30'((a + b) % 64'(MOD));
			OP_SUB: return 30'((a + 64'(MOD) - b) % 64'(MOD));
			OP_MUL: return mod_product(30'(a), 30'(b));
			OP_POW: return mod_power(30'(b), op.exponent);
			OP_DIV: return mod_product(30'(a), mod_power(30'(b), FERMAT_EXP));
			default: return 30'd0;
		endcase
	endfunction

	task automatic queue_op(logic [2:0] opc, logic [31:0] a, logic [31:0] b,
			logic [31:0] e, bit hold = 1'b0);
		arith_op_t op;
		op.opcode = opc;
		op.value_a = a;
		op.value_b = b;
		op.exponent = e;
		op.hold = hold;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	// Operands biased toward zero, all-ones and the neighborhood of multiples of MOD
	function automatic logic [31:0] pick_operand();
		logic [31:0] k;
		k = $urandom_range(4);
		case ($urandom_range(7))
			0: return $urandom_range(3);
			1: return ALL_ONES - $urandom_range(3);
			2: return k * 32'(MOD) + $urandom_range(4) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_exponent();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Sender: offer the next pending item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				residues_due.insert(residues_due.size(), offered_residue);
				ops_by_code[s_tdata[2:0]]++;
				ops_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0
						&& !(pending_ops[0].hold && residues_due.size() != 0)
						&& ((ops_sent >= 350 && ops_sent < 500)
							|| $urandom_range(99) >= 33)) begin
					next_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, next_op.exponent, next_op.value_b,
						next_op.value_a, next_op.opcode};
					offered_residue <= residue_of(next_op);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure, compare each residue with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (residues_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("residue: expected none, got %0d", m_tdata[29:0]);
				end else begin
					want = residues_due.pop_front();
					if (m_tdata[29:0] !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$error("residue: expected %0d, got %0d", want, m_tdata[29:0]);
					end
				end
				if (mismatches == MAX_REPORTS + 1 && m_tdata[29:0] !== want)
					$display("further mismatches are counted but not reported");
				residues_checked++;
			end
			m_tready <= (residues_checked >= 350 && residues_checked < 500)
				|| $urandom_range(99) >= 33;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [2:0] opc;
		logic [31:0] divisor;

		// Edge values, every opcode, zero exponent and divisors that are multiples of MOD
		queue_op(OP_ADD, 32'd0, 32'd0, 32'd0);
		queue_op(OP_ADD, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(OP_ADD, 32'(MOD) - 32'd1, 32'd1, 32'd0);
		queue_op(OP_ADD, 32'(MOD), 32'(MOD), 32'd0);
		queue_op(OP_SUB, 32'd0, 32'd1, 32'd0);
		queue_op(OP_SUB, 32'd5, 32'd3, ALL_ONES);
		queue_op(OP_SUB, ALL_ONES, ALL_ONES, 32'd0);
		queue_op(OP_SUB, 32'd0, 32'(MOD) - 32'd1, 32'd0);
		queue_op(OP_MUL, ALL_ONES, ALL_ONES, 32'd0);
		queue_op(OP_MUL, 32'(MOD) - 32'd1, 32'(MOD) - 32'd1, 32'd0);
		queue_op(OP_MUL, 32'd0, ALL_ONES, ALL_ONES);
		queue_op(OP_POW, 32'd7, 32'd0, 32'd0);
		queue_op(OP_POW, 32'd0, 32'(MOD), 32'd0);
		queue_op(OP_POW, 32'd0, 32'd0, 32'd5);
		queue_op(OP_POW, 32'd0, 32'd2, ALL_ONES);
		queue_op(OP_POW, ALL_ONES, 32'(MOD) - 32'd1, ALL_ONES);
		queue_op(OP_DIV, 32'd1, 32'd2, 32'd0);
		queue_op(OP_DIV, ALL_ONES, ALL_ONES, 32'd0);
		queue_op(OP_DIV, 32'd5, 32'd0, 32'd0);
		queue_op(OP_DIV, 32'd5, 32'(MOD), 32'd0);
		queue_op(OP_DIV, ALL_ONES, 32'd4 * 32'(MOD), 32'd0);
		queue_op(OP_RSVD5, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(OP_RSVD6, 32'd1, 32'd2, 32'd3);
		queue_op(OP_RSVD7, ALL_ONES, 32'd0, ALL_ONES);

		// Random mix; every 200th item first waits for the unit to drain
		for (int i = 0; i < RANDOM_OPS; i++) begin
			case ($urandom_range(19))
				0, 1, 2, 3: opc = OP_ADD;
				4, 5, 6, 7: opc = OP_SUB;
				8, 9, 10, 11: opc = OP_MUL;
				12, 13, 14, 15: opc = OP_POW;
				16, 17, 18: opc = OP_DIV;
				default: begin
					case ($urandom_range(2))
						0: opc = OP_RSVD5;
						1: opc = OP_RSVD6;
						default: opc = OP_RSVD7;
					endcase
				end
			endcase
			divisor = pick_operand();
			if (opc == OP_DIV && $urandom_range(7) == 0)
				divisor = 32'($urandom_range(4)) * 32'(MOD);
			queue_op(opc, pick_operand(), divisor, pick_exponent(), i % 200 == 0);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (residues_due.size() != 0)
			@(posedge clk);
		// Catch any stray result after the last expected one
		repeat (600) @(posedge clk);

		$display("Sent %0d items (add %0d, sub %0d, mul %0d, pow %0d, div %0d, unused %0d);",
			ops_sent, ops_by_code[OP_ADD], ops_by_code[OP_SUB], ops_by_code[OP_MUL],
			ops_by_code[OP_POW], ops_by_code[OP_DIV],
			ops_by_code[OP_RSVD5] + ops_by_code[OP_RSVD6] + ops_by_code[OP_RSVD7]);
		$display("checked %0d residues, %0d mismatches.", residues_checked, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Timeout with %0d residues still due", residues_due.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
